// ----- rtl/arlt_pkg.sv -----
// arlt_pkg: shared types and codes for the address range table lookup
// transaction payload structs, table entry layout and sequencer states
// no dependencies
`timescale 1ns / 1ps

package arlt_pkg;

    localparam int SLOT_W  = 10;
    localparam int ADDR_W  = 32;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 11;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  range_start;
        logic [ADDR_W-1:0]  range_end;
        logic [VALUE_W-1:0] range_value;
        logic [ADDR_W-1:0]  lookup_address;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] match_value;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  range_start;
        logic [ADDR_W-1:0]  range_end;
        logic [VALUE_W-1:0] range_value;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_FETCH,
        ST_CHECK,
        ST_OUTPUT
    } state_t;

endpackage

// ----- rtl/arlt_table_ram.sv -----
// arlt_table_ram: single write port, single registered read port table memory
// holds one range entry per word; depends on arlt_pkg for the entry layout
`timescale 1ns / 1ps

module arlt_table_ram #(
    parameter int DEPTH  = 1024,
    parameter int IDX_W  = 10
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  arlt_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output arlt_pkg::entry_t     rd_data
);
    import arlt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/address_range_table_lookup_top.sv -----
// address_range_table_lookup_top: range table with binary search lookup
// a write gives no result; a lookup runs s search steps (at most ceil(log2(n+1)),
// n = entries in use), then may step back one entry; with n at 0 it goes straight to output
// throughput: one transaction at a time, s_ready low until the result register loads
// reset: synchronous active-low aresetn clears the sequencer, entries_in_use and
// the result valid; table contents stay undefined until written, no clearing pass
`timescale 1ns / 1ps

module address_range_table_lookup_top #(
    parameter int MAX_RANGES = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [arlt_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  arlt_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output arlt_pkg::out_item_t                 m_data
);
    import arlt_pkg::*;

    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int SAT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] entries_reg;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   first_reg, first_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               stepped_reg, stepped_next;
    logic               res_found_reg, res_found_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic               s_accept;
    logic               out_free;
    logic               out_load;
    logic [CNT_W-1:0]   half;
    logic [CNT_W-1:0]   mid;
    logic [SAT_W-1:0]   entries_ext;
    logic [CNT_W-1:0]   n_sat;
    logic               slot_ok;
    logic               step_back;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_OUTPUT) && out_free;

    assign half = count_reg >> 1;
    assign mid  = first_reg + half;

    // entries_in_use saturates at the table depth
    assign entries_ext = SAT_W'(entries_reg);
    assign n_sat = (entries_ext > SAT_W'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
                                                     : CNT_W'(entries_ext);

    assign slot_ok = ({{(32 - SLOT_W){1'b0}}, s_data.slot} < 32'(MAX_RANGES));

    // only the lower-bound result may step back, and never from entry zero
    assign step_back = !stepped_reg && (idx_reg != '0) &&
                       (rd_data.range_start > addr_reg);

    assign wr_en               = s_accept && (s_data.kind == KIND_WRITE) && slot_ok;
    assign wr_addr             = IDX_W'(s_data.slot);
    assign wr_data.range_start = s_data.range_start;
    assign wr_data.range_end   = s_data.range_end;
    assign wr_data.range_value = s_data.range_value;

    arlt_table_ram #(
        .DEPTH (MAX_RANGES),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_data.kind == KIND_LOOKUP)) begin
                    state_next = (n_sat == '0) ? ST_OUTPUT : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                state_next = (count_reg == '0) ? ST_FETCH : ST_COMPARE;
            end
            ST_COMPARE: begin
                state_next = ST_SEARCH;
            end
            ST_FETCH: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = step_back ? ST_FETCH : ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        addr_next      = addr_reg;
        n_next         = n_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        stepped_next   = stepped_reg;
        res_found_next = res_found_reg;
        res_value_next = res_value_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_data.kind == KIND_LOOKUP)) begin
                    addr_next      = s_data.lookup_address;
                    n_next         = n_sat;
                    first_next     = '0;
                    count_next     = n_sat;
                    res_found_next = 1'b0;
                    res_value_next = '0;
                end
            end
            ST_SEARCH: begin
                if (count_reg == '0) begin
                    // past the end clamps to the last entry with no step back
                    if (first_reg >= n_reg) begin
                        idx_next     = IDX_W'(n_reg - 1'b1);
                        stepped_next = 1'b1;
                    end else begin
                        idx_next     = IDX_W'(first_reg);
                        stepped_next = 1'b0;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = mid[IDX_W-1:0];
                end
            end
            ST_COMPARE: begin
                if (rd_data.range_start < addr_reg) begin
                    first_next = mid + 1'b1;
                    count_next = count_reg - half - 1'b1;
                end else begin
                    count_next = half;
                end
            end
            ST_FETCH: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            ST_CHECK: begin
                if (step_back) begin
                    idx_next     = idx_reg - 1'b1;
                    stepped_next = 1'b1;
                end else if ((rd_data.range_start <= addr_reg) &&
                             (rd_data.range_end >= addr_reg)) begin
                    res_found_next = 1'b1;
                    res_value_next = rd_data.range_value;
                end else begin
                    res_found_next = 1'b0;
                    res_value_next = '0;
                end
            end
            ST_OUTPUT: begin
                if (out_load) begin
                    m_valid_next            = 1'b1;
                    m_data_next.found       = res_found_reg;
                    m_data_next.match_value = res_value_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            entries_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                entries_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        n_reg         <= n_next;
        first_reg     <= first_next;
        count_reg     <= count_next;
        idx_reg       <= idx_next;
        stepped_reg   <= stepped_next;
        res_found_reg <= res_found_next;
        res_value_reg <= res_value_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // search window never runs past the entries in use
    a_window_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SEARCH) || (state_reg == ST_COMPARE)) |->
        ((CNT_W + 1)'(first_reg) + (CNT_W + 1)'(count_reg) <= (CNT_W + 1)'(n_reg)))
        else $error("search window exceeds entries in use");

    // a compare step only follows a probe of a nonempty window
    a_compare_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMPARE) |-> (count_reg != '0))
        else $error("compare step with empty window");

    // the selected entry lies inside the table in use
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FETCH) || (state_reg == ST_CHECK)) |->
        (CNT_W'(idx_reg) < n_reg))
        else $error("selected entry beyond entries in use");

    // a miss always reports a zero value
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.found || (m_data_reg.match_value == '0)))
        else $error("miss carries nonzero value");

    // a lookup transaction yields exactly one result load before returning idle
    a_output_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> ((state_reg == ST_IDLE) && m_valid_reg))
        else $error("result load did not return to idle");

endmodule

// ----- tb/range_lookup_compare.sv -----
// range_lookup_compare: watches the config port and both channels of the range table lookup,
// mirrors the table, predicts each lookup result and compares it with what comes out
// depends on arlt_pkg for the payload structs and kind codes
`timescale 1ns / 1ps

module range_lookup_compare #(
    parameter int MAX_RANGES = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [arlt_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  arlt_pkg::in_item_t           s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  arlt_pkg::out_item_t          m_data,
    output int                           mismatches,
    output int                           outstanding
);
    import arlt_pkg::*;

    bit [ADDR_W-1:0]  range_lo [MAX_RANGES];
    bit [ADDR_W-1:0]  range_hi [MAX_RANGES];
    bit [VALUE_W-1:0] range_val[MAX_RANGES];
    bit [COUNT_W-1:0] table_count = '0;
    out_item_t        due_lookups[$];
    out_item_t        want;
    int               mismatch_total = 0;

    // lower-bound search over the used entries, then one step back when the start overshoots
    function automatic out_item_t search_table(input bit [ADDR_W-1:0] addr);
        int unsigned used;
        int unsigned lo_idx;
        int unsigned width;
        int unsigned half;
        int unsigned mid;
        out_item_t   res;
        res    = '0;
        used   = 32'(table_count);
        if (used > MAX_RANGES) begin
            used = MAX_RANGES;
        end
        lo_idx = 0;
        width  = used;
        if (used == 0) begin
            return res;
        end
        while (width > 0) begin
            half = width >> 1;
            mid  = lo_idx + half;
            if (range_lo[mid] < addr) begin
                lo_idx = mid + 1;
                width  = width - (half + 1);
            end else begin
                width = half;
            end
        end
        if (lo_idx >= used) begin
            lo_idx = used - 1;
        end else if (lo_idx != 0 && range_lo[lo_idx] > addr) begin
            lo_idx = lo_idx - 1;
        end
        if (range_lo[lo_idx] <= addr && range_hi[lo_idx] >= addr) begin
            res.found       = 1'b1;
            res.match_value = range_val[lo_idx];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            table_count = '0;
            due_lookups.delete();
        end else begin
            if (cfg_wr_en) begin
                table_count = cfg_wr_data;
            end
            // results are matched before new lookups are queued, a same-edge result is an error
            if (m_valid && m_ready) begin
                if (due_lookups.size() == 0) begin
                    $display("%0t: result with no lookup outstanding, actual found %0b value %h",
                             $time, m_data.found, m_data.match_value);
                    mismatch_total++;
                end else begin
                    want = due_lookups.pop_front();
                    if (m_data.found !== want.found) begin
                        $display("%0t: found mismatch, expected %0b actual %0b",
                                 $time, want.found, m_data.found);
                        mismatch_total++;
                    end
                    if (m_data.match_value !== want.match_value) begin
                        $display("%0t: match_value mismatch, expected %h actual %h",
                                 $time, want.match_value, m_data.match_value);
                        mismatch_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.kind == KIND_WRITE) begin
                    if (s_data.slot < MAX_RANGES) begin
                        range_lo[s_data.slot]  = s_data.range_start;
                        range_hi[s_data.slot]  = s_data.range_end;
                        range_val[s_data.slot] = s_data.range_value;
                    end
                end else begin
                    due_lookups = {due_lookups, search_table(s_data.lookup_address)};
                end
            end
        end
        mismatches  <= mismatch_total;
        outstanding <= due_lookups.size();
    end

endmodule

// ----- tb/address_range_table_lookup_top_tb.sv -----
// address_range_table_lookup_top_tb: drives entry writes, lookups and entry-count settings
// into the range table lookup under bursty input and stalling output, gives the verdict
// depends on arlt_pkg, address_range_table_lookup_top and range_lookup_compare
`timescale 1ns / 1ps

module address_range_table_lookup_top_tb;
    import arlt_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int RANDOM_ITEMS   = 400;
    localparam int PHASE_ITEMS    = 50;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    in_item_t           s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    out_item_t          m_data;
    int                 mismatches;
    int                 outstanding;

    bit [ADDR_W-1:0] entry_lo[TABLE_DEPTH];
    bit [ADDR_W-1:0] entry_hi[TABLE_DEPTH];
    int              active_entries = 0;
    int              burst_left     = 0;
    int              idle_cycles    = 0;
    int              ready_cycle    = 0;
    int              stall_left     = 0;

    address_range_table_lookup_top #(
        .MAX_RANGES(TABLE_DEPTH)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    range_lookup_compare #(
        .MAX_RANGES(TABLE_DEPTH)
    ) lookup_cmp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: free-running, random, sparse periodic and long-stall stretches in turn
    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        case ((ready_cycle / 256) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 9) < 7);
            2: m_ready <= (ready_cycle % 5 == 0);
            default: begin
                if (stall_left > 0) begin
                    m_ready    <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    m_ready    <= 1'b1;
                    stall_left <= $urandom_range(0, 24);
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    // one transaction, with a random gap whenever a burst runs out
    task automatic send_item(input in_item_t item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and wait until every lookup has answered and the block has gone quiet
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_count(input int value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        active_entries = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
    endtask

    task automatic write_entry(input int slot, input bit [ADDR_W-1:0] lo,
                               input bit [ADDR_W-1:0] hi, input bit [VALUE_W-1:0] value);
        in_item_t item;
        item.kind           = KIND_WRITE;
        item.slot           = SLOT_W'(slot);
        item.range_start    = lo;
        item.range_end      = hi;
        item.range_value    = value;
        item.lookup_address = $urandom;
        entry_lo[slot] = lo;
        entry_hi[slot] = hi;
        send_item(item);
    endtask

    task automatic lookup(input bit [ADDR_W-1:0] addr);
        in_item_t item;
        item.kind           = KIND_LOOKUP;
        item.slot           = SLOT_W'($urandom);
        item.range_start    = $urandom;
        item.range_end      = $urandom;
        item.range_value    = VALUE_W'($urandom);
        item.lookup_address = addr;
        send_item(item);
    endtask

    // mostly kept in its own 4M window so the table stays sorted, sometimes anything at all
    task automatic random_write();
        int              slot;
        bit [ADDR_W-1:0] lo;
        bit [ADDR_W-1:0] hi;
        slot = $urandom_range(0, TABLE_DEPTH - 1);
        if ($urandom_range(0, 9) == 0) begin
            lo = $urandom;
            hi = $urandom;
        end else begin
            lo = (32'(slot) << 22) + $urandom_range(0, 32'h1F_FFFF);
            hi = lo + $urandom_range(0, 32'h1F_FFFF);
        end
        write_entry(slot, lo, hi, VALUE_W'($urandom));
    endtask

    // addresses on and around the edges of entries in use, plus extremes and noise
    function automatic bit [ADDR_W-1:0] pick_address();
        int used;
        int idx;
        used = (active_entries == 0) ? TABLE_DEPTH : active_entries;
        idx  = $urandom_range(0, used - 1);
        case ($urandom_range(0, 9))
            0: return entry_lo[idx];
            1: return entry_hi[idx];
            2: return entry_lo[idx] - 1;
            3: return entry_hi[idx] + 1;
            4: return 32'h0;
            5: return 32'hFFFF_FFFF;
            6, 7: begin
                if (entry_hi[idx] >= entry_lo[idx]) begin
                    return entry_lo[idx] + $urandom_range(0, entry_hi[idx] - entry_lo[idx]);
                end
                return entry_lo[idx];
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        bit [ADDR_W-1:0]  lo;
        bit [ADDR_W-1:0]  hi;
        bit [VALUE_W-1:0] value;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table answers not found
        lookup(32'h0);
        lookup(32'hFFFF_FFFF);

        // sorted fill of the whole table, first start above zero, last end at the top
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            lo = (32'(i) << 22) + $urandom_range(0, 32'h1F_FFFF);
            hi = lo + $urandom_range(0, 32'h1F_FFFF);
            if (i == 0) begin
                lo = 32'h100;
            end
            if (i == TABLE_DEPTH - 1) begin
                hi = 32'hFFFF_FFFF;
            end
            value = (i == 5) ? 16'h0000 : (i == 6) ? 16'hFFFF : 16'($urandom);
            write_entry(i, lo, hi, value);
        end

        set_count(TABLE_DEPTH);
        lookup(32'h0);
        lookup(entry_lo[0]);
        lookup(32'hFFFF_FFFF);
        lookup(entry_lo[500]);
        lookup(entry_hi[500]);
        lookup(entry_hi[500] + 1);
        lookup(entry_lo[501] - 1);
        lookup(entry_lo[5]);
        lookup(entry_lo[6]);
        lookup(entry_hi[0] + 1);

        // single entry: everything past it falls back onto entry zero
        set_count(1);
        lookup(32'hFFFF_FFFF);
        lookup(entry_hi[0]);
        lookup(32'h0);

        // count above the table depth saturates
        set_count(2047);
        lookup(32'hFFFF_FFFF);
        lookup(entry_lo[TABLE_DEPTH - 1]);

        // break the ordering with one wide entry in the middle
        write_entry(300, 32'h0, 32'hFFFF_FFFF, 16'h5A5A);
        lookup(entry_hi[299]);
        lookup(32'h4B00_0000);
        lookup(entry_lo[301]);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % PHASE_ITEMS == 0) begin
                case (k / PHASE_ITEMS)
                    0: set_count(TABLE_DEPTH);
                    1: set_count(2);
                    2: set_count(0);
                    3: set_count(TABLE_DEPTH - 1);
                    4: set_count(2047);
                    default: begin
                        if ($urandom_range(0, 1) == 0) begin
                            set_count($urandom_range(1, 32));
                        end else begin
                            set_count($urandom_range(3, TABLE_DEPTH));
                        end
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0) begin
                random_write();
            end else begin
                lookup(pick_address());
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- address_range_table_lookup_top.f -----
rtl/arlt_pkg.sv
rtl/arlt_table_ram.sv
rtl/address_range_table_lookup_top.sv
tb/range_lookup_compare.sv
tb/address_range_table_lookup_top_tb.sv
